// File: hw/rtl/sobel_gradient_magnitude_direction_defines.svh
// ---------------------------------------------------------------------------
// Sobel gradient block: assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_DIRECTION_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DIRECTION_DEFINES_SVH

// same-cycle implication, off during reset
`define SGMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SGMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always checked
`define SGMD_ASSERT_NEXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sgmd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_pkg
// Shared constants and types of the Sobel gradient block.
// ---------------------------------------------------------------------------
package sgmd_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int HEIGHT_CAP  = 4096;
  localparam int MIN_DIM     = 3;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_REG_W = 10;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int PIX_W       = 8;
  localparam int GRAD_W      = 11;
  localparam int ABS_W       = 10;
  localparam int MAG_W       = 8;
  localparam int MAG_LIMIT   = 255;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_ANTI = 2'd1,
    DIR_VERT = 2'd2,
    DIR_DIAG = 2'd3
  } dir_t;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // masked 3x3 neighborhood handed from front to back
  typedef struct packed {
    logic    last;
    window_t pix;
  } qentry_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]         magnitude;
    dir_t                     direction;
    logic                     frame_last;
  } result_t;

endpackage

// File: hw/rtl/sobel_gradient_magnitude_direction.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude_direction
// Streaming 3x3 Sobel gradient with L1 magnitude and direction class.
// ---------------------------------------------------------------------------
// channel | signals                              | moves
// s_*     | tvalid tready tdata[7:0] tuser       | pixel, flush flag
// m_*     | tvalid tready tdata[31:0] tlast      | gradients, magnitude, class
// cfg_*   | we addr data[12:0]                   | image_width, image_height
//
// One pixel per clock sustained while the output accepts results; a result is registered
// through stage 1, the queue, stage A and stage B after the transfer that completes its
// window, and a frame's results lag its pixels by one row plus one pixel. Synchronous
// reset clears control and the window register; the line buffer holds its contents.
// The front and back halves stall independently across a four-entry queue.
// ---------------------------------------------------------------------------
module sobel_gradient_magnitude_direction (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // pixel[7:0]
  input  logic                            s_tuser,   // flush
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // grad_x, grad_y, magnitude, direction
  output logic                            m_tlast,   // frame_last
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [sgmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sgmd_pkg::*;

  logic    push, q_full, pop, q_empty;
  qentry_t push_data, head;
  result_t result;

  sgmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  sgmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  sgmd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tdata = {result.direction, result.magnitude, result.grad_y, result.grad_x};
  assign m_tlast = result.frame_last;

endmodule

// File: hw/rtl/sgmd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module sgmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sgmd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_front
// Input side: frame position, line buffers, 3x3 window and edge masking.
// ---------------------------------------------------------------------------
module sgmd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sgmd_pkg::PIX_W-1:0]          s_tdata,
  input  logic                                s_tuser,
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [sgmd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                push,
  output sgmd_pkg::qentry_t                   push_data,
  input  logic                                q_full
);
  import sgmd_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [WIDTH_REG_W-1:0]  w;
  logic [HEIGHT_REG_W-1:0] h;
  logic [HEIGHT_REG_W:0]   h_p1;

  logic [HEIGHT_REG_W-1:0] row;
  logic [COL_W-1:0]        col;
  logic                    primed;

  logic                    restart;
  logic [HEIGHT_REG_W-1:0] r0, rn;
  logic [COL_W-1:0]        c0, ce, cn;
  logic                    p0, p1;
  logic                    at_last_col, last, pos_ok;
  logic                    top, bottom, left, right;
  logic                    accept;

  logic                    s1_valid, s1_emit, s1_last;
  logic                    s1_top, s1_bottom, s1_left, s1_right;
  logic [PIX_W-1:0]        s1_cur;
  logic [COL_W-1:0]        s1_col;
  logic                    s1_adv;

  logic [2*PIX_W-1:0]      rdata;
  logic [PIX_W-1:0]        up, lo;
  window_t                 win, win_next, win_mask;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_REG_W'(MAX_WIDTH);
      height_reg <= HEIGHT_REG_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IDX_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_reg < WIDTH_REG_W'(MIN_DIM))        w = WIDTH_REG_W'(MIN_DIM);
    else if (width_reg > WIDTH_REG_W'(MAX_WIDTH)) w = WIDTH_REG_W'(MAX_WIDTH);
    else                                          w = width_reg;
    if (height_reg < HEIGHT_REG_W'(MIN_DIM))         h = HEIGHT_REG_W'(MIN_DIM);
    else if (height_reg > HEIGHT_REG_W'(HEIGHT_CAP)) h = HEIGHT_REG_W'(HEIGHT_CAP);
    else                                             h = height_reg;
  end

  assign h_p1 = {1'b0, h} + (HEIGHT_REG_W+1)'(1);

  // position of the incoming item
  always_comb begin
    restart = ({1'b0, row} > h_p1) || (({1'b0, row} == h_p1) && (col != '0));
    r0 = restart ? '0 : row;
    c0 = restart ? '0 : col;
    p0 = restart ? 1'b0 : primed;
    ce = ({1'b0, c0} >= w) ? COL_W'(w - WIDTH_REG_W'(1)) : c0;
    at_last_col = ({1'b0, ce} == (w - WIDTH_REG_W'(1)));
    cn = at_last_col ? '0 : ce + COL_W'(1);
    rn = at_last_col ? r0 + HEIGHT_REG_W'(1) : r0;
    last = ({1'b0, r0} == h_p1) && (ce == '0);
    p1 = p0 || ((r0 == HEIGHT_REG_W'(1)) && (ce == COL_W'(1)));
    if (ce != '0) begin
      pos_ok = (r0 >= HEIGHT_REG_W'(1)) && (r0 <= h);
      top    = (r0 == HEIGHT_REG_W'(1));
      bottom = (r0 == h);
      left   = (ce == COL_W'(1));
      right  = 1'b0;
    end else begin
      pos_ok = (r0 >= HEIGHT_REG_W'(2)) && ({1'b0, r0} <= h_p1);
      top    = (r0 == HEIGHT_REG_W'(2));
      bottom = ({1'b0, r0} == h_p1);
      left   = 1'b0;
      right  = 1'b1;
    end
  end

  assign s1_adv   = s1_valid && (!s1_emit || !q_full);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      primed <= 1'b0;
    end else if (accept) begin
      if (p1 && last) begin
        row    <= '0;
        col    <= '0;
        primed <= 1'b0;
      end else begin
        row    <= rn;
        col    <= cn;
        primed <= p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur    <= s_tuser ? '0 : s_tdata;
      s1_col    <= ce;
      s1_emit   <= p1 && pos_ok;
      s1_last   <= last;
      s1_top    <= top;
      s1_bottom <= bottom;
      s1_left   <= left;
      s1_right  <= right;
    end
  end

  // line buffers: upper row in the high byte, lower row in the low byte
  sgmd_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({lo, s1_cur}),
    .re    (accept),
    .raddr (ce),
    .rdata (rdata)
  );

  assign up = rdata[2*PIX_W-1:PIX_W];
  assign lo = rdata[PIX_W-1:0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = up;
    win_next[1][2] = lo;
    win_next[2][2] = s1_cur;
    win_mask = win_next;
    for (int k = 0; k < 3; k++) begin
      if (s1_top)    win_mask[0][k] = '0;
      if (s1_bottom) win_mask[2][k] = '0;
      if (s1_left)   win_mask[k][0] = '0;
      if (s1_right)  win_mask[k][2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_adv) begin
      win <= win_next;
    end
  end

  assign push           = s1_adv && s1_emit;
  assign push_data.pix  = win_mask;
  assign push_data.last = s1_last;

endmodule

// File: hw/rtl/sgmd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_queue
// Small FIFO of masked windows between front and back.
// ---------------------------------------------------------------------------
module sgmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sgmd_pkg::qentry_t push_data,
  output logic              full,
  input  logic              pop,
  output sgmd_pkg::qentry_t head,
  output logic              empty
);
  import sgmd_pkg::*;

  qentry_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/sgmd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_back
// Output side: Sobel sums, then magnitude and direction class.
// ---------------------------------------------------------------------------
module sgmd_back (
  input  logic              clk,
  input  logic              rst,
  input  sgmd_pkg::qentry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output sgmd_pkg::result_t result
);
  import sgmd_pkg::*;

  logic                     a_valid, a_ready, a_last;
  logic signed [GRAD_W-1:0] a_gx, a_gy;
  logic                     b_valid, b_ready;
  result_t                  b_res;

  logic [ABS_W-1:0]         sum_l, sum_r, sum_t, sum_b;
  logic signed [GRAD_W-1:0] gx, gy;
  logic [ABS_W-1:0]         ax, ay;
  logic [ABS_W:0]           sum;
  logic [13:0]              ay5, ax2, ax12;
  logic                     same_sign;
  dir_t                     dir;
  logic [MAG_W-1:0]         mag;

  // stage A: kernel sums
  always_comb begin
    sum_l = ABS_W'(head.pix[0][0]) + ABS_W'({head.pix[1][0], 1'b0}) + ABS_W'(head.pix[2][0]);
    sum_r = ABS_W'(head.pix[0][2]) + ABS_W'({head.pix[1][2], 1'b0}) + ABS_W'(head.pix[2][2]);
    sum_t = ABS_W'(head.pix[0][0]) + ABS_W'({head.pix[0][1], 1'b0}) + ABS_W'(head.pix[0][2]);
    sum_b = ABS_W'(head.pix[2][0]) + ABS_W'({head.pix[2][1], 1'b0}) + ABS_W'(head.pix[2][2]);
    gx = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
  end

  assign b_ready = !b_valid || m_tready;
  assign a_ready = !a_valid || b_ready;
  assign pop     = !empty && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_gx   <= gx;
      a_gy   <= gy;
      a_last <= head.last;
    end
  end

  // stage B: magnitude and direction
  always_comb begin
    ax   = a_gx[GRAD_W-1] ? ABS_W'(-a_gx) : ABS_W'(a_gx);
    ay   = a_gy[GRAD_W-1] ? ABS_W'(-a_gy) : ABS_W'(a_gy);
    sum  = {1'b0, ax} + {1'b0, ay};
    mag  = (sum > (ABS_W+1)'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : sum[MAG_W-1:0];
    ay5  = 14'({ay, 2'b00}) + 14'(ay);
    ax2  = 14'({ax, 1'b0});
    ax12 = 14'({ax, 3'b000}) + 14'({ax, 2'b00});
    same_sign = (a_gx > 0 && a_gy > 0) || (a_gx < 0 && a_gy < 0);
    priority if (ax == '0 && ay == '0) dir = DIR_HORZ;
    else if (ay5 < ax2)                dir = DIR_HORZ;
    else if (ay5 > ax12)               dir = DIR_VERT;
    else if (same_sign)                dir = DIR_DIAG;
    else                               dir = DIR_ANTI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_res.grad_x     <= a_gx;
      b_res.grad_y     <= a_gy;
      b_res.magnitude  <= mag;
      b_res.direction  <= dir;
      b_res.frame_last <= a_last;
    end
  end

  assign m_tvalid = b_valid;
  assign result   = b_res;

endmodule

// File: hw/rtl/sgmd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_checker
// Port-level checks on the Sobel gradient block, bound to the top level.
// ---------------------------------------------------------------------------
`include "sobel_gradient_magnitude_direction_defines.svh"

module sgmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // nothing can come out in the cycle right after reset
  `SGMD_ASSERT_NEXT_ALL(a_rst_quiet, rst, !m_tvalid, "result valid right after reset")

  // a stalled result holds
  `SGMD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  // zero gradient gives zero magnitude and horizontal class
  `SGMD_ASSERT_NOW(a_zero_grad, m_tvalid && m_tdata[10:0] == 11'd0 && m_tdata[21:11] == 11'd0, m_tdata[31:22] == 10'd0, "zero gradient with nonzero magnitude or class")

  // input back-pressure only starts right after a transfer or with output pending
  `SGMD_ASSERT_NOW(a_in_live, s_tvalid && !s_tready, m_tvalid || $past(m_tvalid) || !$past(s_tready) || $past(s_tvalid && s_tready), "input stalled with output idle")

endmodule

bind sobel_gradient_magnitude_direction sgmd_checker u_sgmd_checker (.*);

// File: bench/sobel_gradient_magnitude_direction_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude_direction_tb
// Self-checking bench for the streaming Sobel gradient block. Frames of
// random and edge-case pixels, with padding items and some malformed
// sequences, are pushed through the pixel stream while both stream sides
// stall at random. A scoreboard tracks row stores, window and position,
// predicts gradients, magnitude, direction and end of frame, and checks
// every result transfer in order. Frame size is changed between frames,
// outside the legal range, and in mid-frame.
// ---------------------------------------------------------------------------
module sobel_gradient_magnitude_direction_tb;
  import sgmd_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 450;

  class gradient_scoreboard;
    typedef struct {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic [MAG_W-1:0]         mag;
      dir_t                     dir;
      logic                     eof;
    } gradient_t;

    gradient_t               expected_gradients[$];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [PIX_W-1:0]        row_two_up [MAX_WIDTH];
    logic [PIX_W-1:0]        row_one_up [MAX_WIDTH];
    int                      nbhd [9];
    int                      next_row;
    int                      next_col;
    bit                      primed;
    int                      mismatches;
    int                      checked;

    function new();
      width_reg  = 10'd512;
      height_reg = 13'd512;
      foreach (row_two_up[i]) begin
        row_two_up[i] = '0;
        row_one_up[i] = '0;
      end
      foreach (nbhd[i]) nbhd[i] = 0;
      next_row   = 0;
      next_col   = 0;
      primed     = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic idx, int value);
      if (idx == CFG_IDX_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
      else height_reg = value[HEIGHT_REG_W-1:0];
    endfunction

    function int eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
      return int'(height_reg);
    endfunction

    // items left up to and including the frame's final padding item
    function int items_to_frame_end();
      int w, h, r, c;
      w = eff_width();
      h = eff_height();
      r = next_row;
      c = next_col;
      if (r > h + 1 || (r == h + 1 && c > 0)) begin
        r = 0;
        c = 0;
      end
      if (c >= w) c = w - 1;
      return (h + 1 - r) * w - c + 1;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic flush);
      int        w, h, r, c, pr, pc, oy, ox, gx, gy, ax, ay, mag;
      int        win [9];
      logic [PIX_W-1:0] cur, up, mid;
      bit        eof;
      gradient_t g;
      w = eff_width();
      h = eff_height();
      // position left beyond a shrunken frame restarts the frame
      if (next_row > h + 1 || (next_row == h + 1 && next_col > 0)) begin
        next_row = 0;
        next_col = 0;
        primed   = 1'b0;
      end
      if (next_col >= w) next_col = w - 1;
      r = next_row;
      c = next_col;

      cur = flush ? '0 : pix;
      up  = row_two_up[c];
      mid = row_one_up[c];
      row_two_up[c] = mid;
      row_one_up[c] = cur;
      for (int i = 0; i < 3; i++) begin
        nbhd[i*3]     = nbhd[i*3 + 1];
        nbhd[i*3 + 1] = nbhd[i*3 + 2];
      end
      nbhd[2] = int'(up);
      nbhd[5] = int'(mid);
      nbhd[8] = int'(cur);

      if (r == 1 && c == 1) primed = 1'b1;
      eof = (r == h + 1 && c == 0);
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      next_row = r;
      next_col = c;
      if (!primed) return;

      // window center trails the incoming item by one row and one pixel
      pr = eof ? h + 1 : (c == 0 ? r - 1 : r);
      pc = eof ? 0 : (c == 0 ? w - 1 : c - 1);
      if (pc >= 1) begin
        oy = pr - 1;
        ox = pc - 1;
      end else begin
        oy = pr - 2;
        ox = w - 1;
      end
      if (oy < 0 || oy >= h) return;

      foreach (win[i]) win[i] = nbhd[i];
      if (oy == 0) begin
        win[0] = 0; win[1] = 0; win[2] = 0;
      end
      if (oy == h - 1) begin
        win[6] = 0; win[7] = 0; win[8] = 0;
      end
      if (ox == 0) begin
        win[0] = 0; win[3] = 0; win[6] = 0;
      end
      if (ox == w - 1) begin
        win[2] = 0; win[5] = 0; win[8] = 0;
      end

      gx  = (win[2] + 2*win[5] + win[8]) - (win[0] + 2*win[3] + win[6]);
      gy  = (win[6] + 2*win[7] + win[8]) - (win[0] + 2*win[1] + win[2]);
      ax  = gx < 0 ? -gx : gx;
      ay  = gy < 0 ? -gy : gy;
      mag = ax + ay;
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;

      if (ax == 0 && ay == 0) g.dir = DIR_HORZ;
      else if (ay*5 < ax*2) g.dir = DIR_HORZ;
      else if (ay*5 > ax*12) g.dir = DIR_VERT;
      else if ((gx > 0 && gy > 0) || (gx < 0 && gy < 0)) g.dir = DIR_DIAG;
      else g.dir = DIR_ANTI;
      g.gx  = GRAD_W'(gx);
      g.gy  = GRAD_W'(gy);
      g.mag = MAG_W'(mag);
      g.eof = eof;
      expected_gradients.push_back(g);

      if (eof) begin
        next_row = 0;
        next_col = 0;
        primed   = 1'b0;
      end
    endfunction

    function void check_gradient(logic [31:0] data, logic eof);
      gradient_t got, want;
      got.gx  = data[10:0];
      got.gy  = data[21:11];
      got.mag = data[29:22];
      got.dir = dir_t'(data[31:30]);
      got.eof = eof;
      checked++;
      if (expected_gradients.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: gx=%0d gy=%0d mag=%0d dir=%0d last=%0b",
                   got.gx, got.gy, got.mag, got.dir, got.eof);
        return;
      end
      want = expected_gradients.pop_front();
      if (got.gx !== want.gx || got.gy !== want.gy || got.mag !== want.mag ||
          got.dir !== want.dir || got.eof !== want.eof) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp gx=%0d gy=%0d mag=%0d dir=%0d last=%0b, got gx=%0d gy=%0d mag=%0d dir=%0d last=%0b",
                   checked, want.gx, want.gy, want.mag, want.dir, want.eof,
                   got.gx, got.gy, got.mag, got.dir, got.eof);
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tlast;
  logic                  cfg_we   = 1'b0;
  logic                  cfg_addr = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gradient_scoreboard sb = new();
  bit                 steady = 1'b0;
  int                 idle_cycles = 0;

  sobel_gradient_magnitude_direction uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_gradient(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [PIX_W-1:0] pix, input logic flush);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= flush;
    do @(posedge clk); while (!s_tready);
  endtask

  // n items, the last pad of them padding; flat >= 0 gives a constant image
  task automatic send_run(input int n, input int pad, input int noise_pct, input int flat);
    logic [PIX_W-1:0] pix;
    logic             flush;
    int               roll;
    for (int k = 0; k < n; k++) begin
      flush = (k >= n - pad);
      if ($urandom_range(0, 99) < noise_pct) flush = ~flush;
      roll = $urandom_range(0, 9);
      if (flat >= 0) pix = PIX_W'(flat);
      else if (roll == 0) pix = '0;
      else if (roll == 1) pix = '1;
      else pix = PIX_W'($urandom_range(0, 255));
      send_item(pix, flush);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_gradients.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    int run;
    int gap;
    bit squeezed;
    squeezed = 1'b0;
    wait (rst === 1'b0);
    forever begin
      // long hold-off so the block fills up and stalls its input
      if (!squeezed && sb.checked >= 100 && s_tvalid) begin
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      m_tready <= 1'b1;
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int edge_a  [9]  = '{0, 128, 255, 0, 77, 255, 0, 200, 255};
    int edge_b  [13] = '{255, 255, 255, 9, 0, 3, 0, 255, 0, 0, 0, 170, 0};
    bit flush_b [13] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0, 1};
    int n;
    int total;
    int w_pick;
    int h_pick;
    int noise;
    int flat;
    int roll;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // below-range sizes clamp to 3x3
    write_reg(CFG_IDX_WIDTH, 0);
    write_reg(CFG_IDX_HEIGHT, 1);
    for (int i = 0; i < 9; i++) send_item(PIX_W'(edge_a[i]), 1'b0);
    repeat (4) send_item(8'ha5, 1'b1);
    // flush inside the frame, pixel in a padding slot
    for (int i = 0; i < 13; i++) send_item(PIX_W'(edge_b[i]), flush_b[i]);
    wait_idle();

    // mid-frame size changes: narrower row, then a frame end already passed
    write_reg(CFG_IDX_WIDTH, 8);
    write_reg(CFG_IDX_HEIGHT, 6);
    send_run(29, 0, 0, -1);
    wait_idle();
    write_reg(CFG_IDX_WIDTH, 5);
    send_run(2, 0, 0, -1);
    wait_idle();
    write_reg(CFG_IDX_HEIGHT, 3);
    wait_idle();
    n = sb.items_to_frame_end();
    send_run(n, sb.eff_width() + 1, 0, -1);
    wait_idle();

    // above-range height clamps to the tallest frame; a lower height then restarts it
    write_reg(CFG_IDX_WIDTH, 3);
    write_reg(CFG_IDX_HEIGHT, 8191);
    send_run(24, 0, 2, -1);
    wait_idle();
    write_reg(CFG_IDX_HEIGHT, 3);
    n = sb.items_to_frame_end();
    send_run(n, sb.eff_width() + 1, 0, -1);
    wait_idle();

    total = 0;
    while (total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        wait_idle();
        w_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        h_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        write_reg(CFG_IDX_WIDTH, w_pick);
        write_reg(CFG_IDX_HEIGHT, h_pick);
      end
      roll  = $urandom_range(0, 9);
      noise = (roll < 7) ? 0 : (roll < 9) ? 3 : 40;
      flat  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : -1;
      steady = ($urandom_range(0, 3) == 0);
      n = sb.eff_width() * sb.eff_height() + sb.eff_width() + 1;
      send_run(n, sb.eff_width() + 1, noise, flat);
      total += n;
    end
    steady = 1'b0;
    wait_idle();

    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sgmd_pkg.sv
hw/rtl/sgmd_ram.sv
hw/rtl/sgmd_front.sv
hw/rtl/sgmd_queue.sv
hw/rtl/sgmd_back.sv
hw/rtl/sobel_gradient_magnitude_direction.sv
hw/rtl/sgmd_checker.sv
bench/sobel_gradient_magnitude_direction_tb.sv
